// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clk edge, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Next-cycle implication checked at every rising clk edge, disabled during reset.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/crc8fcr_pkg.sv -----
// Types, constants and the CRC-8 step function of the framed command receiver.
package crc8fcr_pkg;

	localparam logic [7:0] HDR_FIRST   = 8'hBB;
	localparam logic [7:0] HDR_SECOND  = 8'hCC;
	localparam logic [7:0] REPLY_FIRST = 8'hAA;
	localparam logic [7:0] CRC_POLY    = 8'h31;
	localparam logic [7:0] CRC_INIT    = 8'hFF;
	localparam logic [7:0] CRC_TOPBIT  = 8'h80;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [1:0] SLOT_AA    = 2'd0;
	localparam logic [1:0] SLOT_CC    = 2'd1;
	localparam logic [1:0] SLOT_COUNT = 2'd2;
	localparam logic [1:0] SLOT_CRC   = 2'd3;

	typedef struct packed {
		logic [7:0]  count;
		logic [15:0] freq;
	} reply_cmd_t;

	typedef struct packed {
		logic       valid;
		reply_cmd_t cmd;
	} q_rd_t;

	function automatic logic [7:0] crc8_feed(logic [7:0] acc, logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((r & CRC_TOPBIT) != 8'h00) begin
				r = {r[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	localparam logic [7:0] HDR_FIRST_CRC = crc8_feed(CRC_INIT, HDR_FIRST);
	localparam logic [7:0] REPLY_SEED    = crc8_feed(crc8_feed(CRC_INIT, REPLY_FIRST), HDR_SECOND);

endpackage

// ----- rtl/crc8fcr_front.sv -----
// Front end: frame hunting, CRC check and reply request generation.
module crc8fcr_front
	import crc8fcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       push_valid,
	output reply_cmd_t push_cmd
);

	typedef enum logic [4:0] {
		PH_HUNT = 5'b00001,
		PH_HDR2 = 5'b00010,
		PH_FLO  = 5'b00100,
		PH_FHI  = 5'b01000,
		PH_CHK  = 5'b10000
	} phase_t;

	phase_t     phase_q;
	logic [7:0] crc_q;
	logic [7:0] freq_lo_q;
	logic [7:0] freq_hi_q;
	logic [7:0] count_q;
	logic       accept;
	logic [7:0] crc_step;

	assign rx_stall   = (phase_q == PH_CHK) && q_full;
	assign accept     = rx_valid && !rx_stall;
	assign crc_step   = crc8_feed(crc_q, rx_byte);
	assign push_valid = accept && (phase_q == PH_CHK) && (rx_byte == crc_q);
	assign push_cmd   = '{count: count_q + 8'd1, freq: {freq_hi_q, freq_lo_q}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			crc_q   <= CRC_INIT;
			count_q <= 8'd0;
		end else if (accept) begin
			case (phase_q)
				PH_HDR2: begin
					if (rx_byte == HDR_SECOND) begin
						crc_q   <= crc_step;
						phase_q <= PH_FLO;
					end else if (rx_byte == HDR_FIRST) begin
						crc_q   <= HDR_FIRST_CRC;
						phase_q <= PH_HDR2;
					end else begin
						crc_q   <= CRC_INIT;
						phase_q <= PH_HUNT;
					end
				end
				PH_FLO: begin
					crc_q   <= crc_step;
					phase_q <= PH_FHI;
				end
				PH_FHI: begin
					crc_q   <= crc_step;
					phase_q <= PH_CHK;
				end
				PH_CHK: begin
					crc_q   <= CRC_INIT;
					phase_q <= PH_HUNT;
					if (push_valid) begin
						count_q <= count_q + 8'd1;
					end
				end
				default: begin
					if (rx_byte == HDR_FIRST) begin
						crc_q   <= HDR_FIRST_CRC;
						phase_q <= PH_HDR2;
					end else begin
						crc_q   <= CRC_INIT;
						phase_q <= PH_HUNT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_FLO)) begin
			freq_lo_q <= rx_byte;
		end
		if (accept && (phase_q == PH_FHI)) begin
			freq_hi_q <= rx_byte;
		end
	end

endmodule

// ----- rtl/crc8fcr_queue.sv -----
// Short request queue between the front end and the reply sequencer.
module crc8fcr_queue
	import crc8fcr_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  reply_cmd_t push_cmd,
	output logic       full,
	input  logic       pop,
	output q_rd_t      rd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	reply_cmd_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign do_push  = push_valid && !full;
	assign do_pop   = pop && (cnt_q != '0);
	assign rd.valid = (cnt_q != '0);
	assign rd.cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/crc8fcr_back.sv -----
// Back end: reply sequencer that sends four bytes per queued request.
module crc8fcr_back
	import crc8fcr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  q_rd_t       q_rd,
	output logic        pop,
	output logic        tx_valid,
	input  logic        tx_stall,
	output logic [7:0]  tx_byte,
	output logic        last_of_reply,
	output logic [15:0] tone_frequency,
	output logic        tone_on
);

	logic       busy_q;
	logic [1:0] slot_q;
	reply_cmd_t cmd_q;
	logic [7:0] crc_q;
	logic       advance;

	assign tx_valid       = busy_q;
	assign advance        = busy_q && !tx_stall;
	assign last_of_reply  = (slot_q == SLOT_CRC);
	assign pop            = q_rd.valid && (!busy_q || (advance && last_of_reply));
	assign tone_frequency = cmd_q.freq;
	assign tone_on        = |cmd_q.freq;

	always_comb begin
		case (slot_q)
			SLOT_AA:    tx_byte = REPLY_FIRST;
			SLOT_CC:    tx_byte = HDR_SECOND;
			SLOT_COUNT: tx_byte = cmd_q.count;
			default:    tx_byte = crc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= SLOT_AA;
		end else if (pop) begin
			busy_q <= 1'b1;
			slot_q <= SLOT_AA;
		end else if (advance) begin
			if (last_of_reply) begin
				busy_q <= 1'b0;
			end else begin
				slot_q <= slot_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_rd.cmd;
			crc_q <= crc8_feed(REPLY_SEED, q_rd.cmd.count);
		end
	end

endmodule

// ----- rtl/crc8_framed_command_receiver_unit.sv -----
// The first reply byte follows a good frame's request via the queue and the sequencer.
// One received byte per cycle unless rx_stall is high; each good frame gets a four-byte
// reply, sent one byte per cycle from the queue unless tx_stall is high.
// The front end stalls only on a check byte while the request queue is full.
// Reset (arst_n low, asynchronous): hunting for a header, CRC at 0xFF, count at zero,
// queue empty, no reply pending.
`include "assert_macros.svh"
module crc8_framed_command_receiver_unit
	import crc8fcr_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        tx_valid,
	input  logic        tx_stall,
	output logic [7:0]  tx_byte,
	output logic        last_of_reply,
	output logic [15:0] tone_frequency,
	output logic        tone_on
);

	logic       push_valid;
	reply_cmd_t push_cmd;
	logic       q_full;
	logic       pop;
	q_rd_t      q_rd;

	crc8fcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_cmd   (push_cmd)
	);

	crc8fcr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.rd         (q_rd)
	);

	crc8fcr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_rd           (q_rd),
		.pop            (pop),
		.tx_valid       (tx_valid),
		.tx_stall       (tx_stall),
		.tx_byte        (tx_byte),
		.last_of_reply  (last_of_reply),
		.tone_frequency (tone_frequency),
		.tone_on        (tone_on)
	);

	`ASSERT_CLK(a_no_push_when_full, push_valid |-> !q_full, "request pushed into full queue")
	`ASSERT_NEXT(a_reply_continues, tx_valid && !tx_stall && !last_of_reply, tx_valid, "reply broken before its last byte")
	`ASSERT_NEXT(a_idle_after_reply, tx_valid && !tx_stall && last_of_reply && !q_rd.valid, !tx_valid, "reply byte without pending request")
	`ASSERT_CLK(a_pop_only_valid, pop |-> q_rd.valid, "pop from empty queue")

endmodule
